// File: hw/rtl/ttcw_pkg.sv
// Shared constants and types for the text terminal cell writer.
// Holds field widths, column counts, reciprocal multipliers and code names.
// No dependencies.
`default_nettype none

package ttcw_pkg;

  localparam int DEF_SCREEN_DEPTH      = 16384;
  localparam int DEF_LINE_COUNT_PIXELS = 480;

  localparam int CURSOR_W   = 14;
  localparam int CHAR_W     = 8;
  localparam int COLOUR_W   = 8;
  localparam int CELL_W     = CHAR_W + 2 * COLOUR_W;
  localparam int FONT_W     = 4;
  localparam int FONT_N     = 1 << FONT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int COLS_W     = 7;
  // cursor arithmetic needs one bit over the cursor: pos + 1, base + cols
  localparam int POS_W      = CURSOR_W + 1;
  localparam int CURSOR_CAP = (1 << CURSOR_W) - 1;

  localparam logic [COLS_W-1:0] COLS_WIDE   = 7'd80;
  localparam logic [COLS_W-1:0] COLS_NARROW = 7'd71;

  // x / cols ~= (x * RECIP) >> RECIP_SHIFT, low by at most one for x < 2**RECIP_SHIFT
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 14;
  localparam int PROD_W      = POS_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam int QC_W        = QUOT_W + COLS_W;
  localparam logic [RECIP_W-1:0] RECIP_WIDE   = RECIP_W'((1 << RECIP_SHIFT) / 80);
  localparam logic [RECIP_W-1:0] RECIP_NARROW = RECIP_W'((1 << RECIP_SHIFT) / 71);

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TILDE = 8'h7E;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;

  localparam logic [COLOUR_W-1:0] FG_BLANK    = 8'd255;
  localparam logic [COLOUR_W-1:0] BG_BLANK    = 8'd0;
  localparam logic [COLOUR_W-1:0] TEXT_RESET  = 8'd182;
  localparam logic [COLOUR_W-1:0] BACK_RESET  = 8'd0;
  localparam logic [CELL_W-1:0]   BLANK_CELL  = {BG_BLANK, FG_BLANK, CHAR_SPACE};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FONT = 2'd0,
    CFG_WIDE = 2'd1,
    CFG_TEXT = 2'd2,
    CFG_BACK = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_CR     = 2'd0,
    OP_LF     = 2'd1,
    OP_SETTLE = 2'd2
  } op_t;

endpackage

`default_nettype wire

// File: hw/rtl/text_terminal_cell_writer_core.sv
// Character-cell text terminal: screen store, cursor, scroll engine.
// Depends on ttcw_pkg.
//
// After reset the block sweeps the whole screen store to blank cells, one cell per clock,
// and stalls input meanwhile (configuration writes are taken at any time). A read
// transaction issues a synchronous store read on accept, then loads the result in S_READ.
// A printable byte that does not push the cursor off the screen is written to its cell
// on the accept edge. CR, and LF without scroll, pass through the divide-by-columns unit
// (reciprocal multiply, then a correcting subtract) before S_POST loads the cursor. A
// scroll walks the screen through the store's read and write ports, one cell per cycle.
`default_nettype none

module text_terminal_cell_writer_core #(
  parameter int SCREEN_DEPTH      = ttcw_pkg::DEF_SCREEN_DEPTH,
  parameter int LINE_COUNT_PIXELS = ttcw_pkg::DEF_LINE_COUNT_PIXELS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_mode,
  input  logic [ttcw_pkg::CHAR_W-1:0]      in_char_code,
  input  logic [ttcw_pkg::CURSOR_W-1:0]    in_cell_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ttcw_pkg::CURSOR_W-1:0]    out_cursor_pos,
  output logic [ttcw_pkg::CHAR_W-1:0]      out_cell_char,
  output logic [ttcw_pkg::COLOUR_W-1:0]    out_cell_fg,
  output logic [ttcw_pkg::COLOUR_W-1:0]    out_cell_bg,
  output logic                             out_scrolled,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ttcw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttcw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ttcw_pkg::*;

  localparam int AW      = $clog2(SCREEN_DEPTH);
  localparam int DW      = $clog2(SCREEN_DEPTH + 1);
  localparam int SCR_CAP = (SCREEN_DEPTH > CURSOR_CAP) ? CURSOR_CAP : SCREEN_DEPTH;
  localparam logic [DW-1:0] DEPTH_L  = DW'(SCREEN_DEPTH);
  localparam logic [AW-1:0] LAST_ROW = AW'(SCREEN_DEPTH - 1);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_READ   = 8'b0000_0100,
    S_DMUL   = 8'b0000_1000,
    S_DFIX   = 8'b0001_0000,
    S_POST   = 8'b0010_0000,
    S_WALK   = 8'b0100_0000,
    S_WDRAIN = 8'b1000_0000
  } state_t;

  // ---------------------------------------------------------------- screen size tables
  logic [CURSOR_W-1:0] total_wide   [FONT_N];
  logic [CURSOR_W-1:0] total_narrow [FONT_N];

  for (genvar g = 0; g < FONT_N; g++) begin : g_total
    localparam int RawRows  = LINE_COUNT_PIXELS / (g + 3);
    localparam int ColsW    = int'(COLS_WIDE);
    localparam int ColsN    = int'(COLS_NARROW);
    localparam int RowsW    = (RawRows * ColsW > SCR_CAP) ? SCR_CAP / ColsW : RawRows;
    localparam int RowsN    = (RawRows * ColsN > SCR_CAP) ? SCR_CAP / ColsN : RawRows;
    localparam int RowsWMin = (RowsW < 1) ? 1 : RowsW;
    localparam int RowsNMin = (RowsN < 1) ? 1 : RowsN;
    assign total_wide[g]   = CURSOR_W'(RowsWMin * ColsW);
    assign total_narrow[g] = CURSOR_W'(RowsNMin * ColsN);
  end

  // ---------------------------------------------------------------- configuration
  logic [FONT_W-1:0]   font_r;
  logic                wide_r;
  logic [COLOUR_W-1:0] text_r;
  logic [COLOUR_W-1:0] back_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_r <= '0;
      wide_r <= 1'b1;
      text_r <= TEXT_RESET;
      back_r <= BACK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FONT: font_r <= cfg_data[FONT_W-1:0];
        CFG_WIDE: wide_r <= cfg_data[0];
        CFG_TEXT: text_r <= cfg_data;
        CFG_BACK: back_r <= cfg_data;
      endcase
    end
  end

  logic [COLS_W-1:0]   cols_now;
  logic [RECIP_W-1:0]  recip_now;
  logic [CURSOR_W-1:0] total_now;

  assign cols_now  = wide_r ? COLS_WIDE : COLS_NARROW;
  assign recip_now = wide_r ? RECIP_WIDE : RECIP_NARROW;
  assign total_now = wide_r ? total_wide[font_r] : total_narrow[font_r];

  // ---------------------------------------------------------------- state
  state_t              state_r, state_nxt;
  logic [CURSOR_W-1:0] cursor_r, cursor_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    x_r, x_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [POS_W-1:0]    base_r, base_nxt;
  logic [POS_W-1:0]    shift_r, shift_nxt;
  op_t                 op_r, op_nxt;
  logic [CURSOR_W-1:0] walk_r, walk_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic                rd_ok_r, rd_ok_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [CURSOR_W-1:0] out_cursor_r, out_cursor_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic [COLOUR_W-1:0] out_fg_r, out_fg_nxt;
  logic [COLOUR_W-1:0] out_bg_r, out_bg_nxt;
  logic                out_scr_r, out_scr_nxt;

  logic                wr_pend_r, wr_pend_nxt;
  logic [CURSOR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic                wr_copy_r, wr_copy_nxt;

  logic [CELL_W-1:0]   rdata_r;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                put_we;

  logic                ld;
  logic [CURSOR_W-1:0] ld_cursor;
  logic [CELL_W-1:0]   ld_cell;
  logic                ld_scr;

  logic                in_acc;
  logic                printable;
  logic                cursor_in_store;
  logic                idx_in_store;
  logic [POS_W-1:0]    pos_inc;
  logic [POS_W-1:0]    total_ext;
  logic [POS_W-1:0]    base_plus;
  logic [QUOT_W-1:0]   q_est;
  logic [QC_W-1:0]     qc;
  logic [QC_W-1:0]     rem;
  logic [POS_W-1:0]    walk_src;
  logic                walk_copy;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign printable = (in_char_code >= CHAR_SPACE) && (in_char_code <= CHAR_TILDE);
  assign cursor_in_store = DW'(cursor_r) < DEPTH_L;
  assign idx_in_store    = DW'(in_cell_index) < DEPTH_L;
  assign total_ext = POS_W'(total_now);
  assign pos_inc   = POS_W'(cursor_r) + POS_W'(1);
  assign base_plus = base_r + POS_W'(cols_now);
  assign q_est     = prod_r[PROD_W-1:RECIP_SHIFT];
  assign qc        = QC_W'(q_est) * QC_W'(cols_now);
  assign rem       = QC_W'(x_r) - qc;
  assign walk_src  = POS_W'(walk_r) + shift_r;
  assign walk_copy = walk_src < total_ext;

  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    x_nxt      = x_r;
    prod_nxt   = prod_r;
    base_nxt   = base_r;
    shift_nxt  = shift_r;
    op_nxt     = op_r;
    walk_nxt   = walk_r;
    clr_nxt    = clr_r;
    rd_ok_nxt  = rd_ok_r;
    rd_en      = 1'b0;
    rd_addr    = '0;
    put_we     = 1'b0;
    ld         = 1'b0;
    ld_cursor  = cursor_r;
    ld_cell    = '0;
    ld_scr     = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_ROW) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_mode) begin
            rd_en     = 1'b1;
            rd_addr   = AW'(in_cell_index);
            rd_ok_nxt = idx_in_store;
            state_nxt = S_READ;
          end else if (printable) begin
            put_we = cursor_in_store;
            if (pos_inc < total_ext) begin
              ld        = 1'b1;
              ld_cursor = pos_inc[CURSOR_W-1:0];
            end else begin
              pos_nxt   = pos_inc;
              x_nxt     = pos_inc - total_ext;
              op_nxt    = OP_SETTLE;
              state_nxt = S_DMUL;
            end
          end else if (in_char_code == CHAR_CR || in_char_code == CHAR_LF) begin
            x_nxt     = POS_W'(cursor_r);
            op_nxt    = (in_char_code == CHAR_CR) ? OP_CR : OP_LF;
            state_nxt = S_DMUL;
          end else begin
            ld = 1'b1;
          end
        end
      end
      S_READ: begin
        ld        = 1'b1;
        ld_cell   = rd_ok_r ? rdata_r : '0;
        state_nxt = S_IDLE;
      end
      S_DMUL: begin
        prod_nxt  = PROD_W'(x_r) * PROD_W'(recip_now);
        state_nxt = S_DFIX;
      end
      S_DFIX: begin
        // estimate may be one short: fold the remainder once
        base_nxt  = (rem >= QC_W'(cols_now)) ? POS_W'(qc + QC_W'(cols_now)) : POS_W'(qc);
        state_nxt = S_POST;
      end
      S_POST: begin
        unique case (op_r)
          OP_CR: begin
            ld        = 1'b1;
            ld_cursor = base_r[CURSOR_W-1:0];
            state_nxt = S_IDLE;
          end
          OP_LF: begin
            if (base_plus < total_ext) begin
              ld        = 1'b1;
              ld_cursor = base_plus[CURSOR_W-1:0];
              state_nxt = S_IDLE;
            end else begin
              pos_nxt   = base_plus;
              x_nxt     = base_plus - total_ext;
              op_nxt    = OP_SETTLE;
              state_nxt = S_DMUL;
            end
          end
          OP_SETTLE: begin
            // whole rows to drop: floor((pos - total) / cols) + 1
            shift_nxt = base_plus;
            pos_nxt   = pos_r - base_plus;
            walk_nxt  = '0;
            state_nxt = S_WALK;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_WALK: begin
        rd_en    = walk_copy;
        rd_addr  = AW'(walk_src[CURSOR_W-1:0]);
        walk_nxt = walk_r + 1'b1;
        if (walk_r == total_now - 1'b1) begin
          state_nxt = S_WDRAIN;
        end
      end
      S_WDRAIN: begin
        ld        = 1'b1;
        ld_cursor = pos_r[CURSOR_W-1:0];
        ld_scr    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt  = out_valid_r && out_stall;
    out_cursor_nxt = out_cursor_r;
    out_char_nxt   = out_char_r;
    out_fg_nxt     = out_fg_r;
    out_bg_nxt     = out_bg_r;
    out_scr_nxt    = out_scr_r;
    cursor_nxt     = cursor_r;
    if (ld) begin
      out_valid_nxt  = 1'b1;
      out_cursor_nxt = ld_cursor;
      out_char_nxt   = ld_cell[CHAR_W-1:0];
      out_fg_nxt     = ld_cell[CHAR_W +: COLOUR_W];
      out_bg_nxt     = ld_cell[CHAR_W+COLOUR_W +: COLOUR_W];
      out_scr_nxt    = ld_scr;
      cursor_nxt     = ld_cursor;
    end

    // walk write lands in the cycle after its read, from registered address and data
    wr_pend_nxt = (state_r == S_WALK);
    wr_addr_nxt = walk_r;
    wr_copy_nxt = walk_copy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cursor_r    <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      wr_pend_r   <= 1'b0;
      op_r        <= OP_CR;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      wr_pend_r   <= wr_pend_nxt;
      op_r        <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    x_r          <= x_nxt;
    prod_r       <= prod_nxt;
    base_r       <= base_nxt;
    shift_r      <= shift_nxt;
    walk_r       <= walk_nxt;
    rd_ok_r      <= rd_ok_nxt;
    out_cursor_r <= out_cursor_nxt;
    out_char_r   <= out_char_nxt;
    out_fg_r     <= out_fg_nxt;
    out_bg_r     <= out_bg_nxt;
    out_scr_r    <= out_scr_nxt;
    wr_addr_r    <= wr_addr_nxt;
    wr_copy_r    <= wr_copy_nxt;
  end

  // ---------------------------------------------------------------- screen store
  logic [CELL_W-1:0] mem [SCREEN_DEPTH];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = BLANK_CELL;
    priority if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
    end else if (put_we) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(cursor_r);
      mem_wdata = {back_r, text_r, in_char_code};
    end else if (wr_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(wr_addr_r);
      mem_wdata = wr_copy_r ? rdata_r : BLANK_CELL;
    end else begin
      mem_we    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------- outputs
  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_cursor_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_fg    = out_fg_r;
  assign out_cell_bg    = out_bg_r;
  assign out_scrolled   = out_scr_r;

  // ---------------------------------------------------------------- checks
  a_walk_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && wr_pend_r && walk_copy) |->
      (POS_W'(wr_addr_r) < walk_src))
    else $error("scroll walk overwrote a cell before reading it");

  a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POST) |->
      (base_r <= x_r && (x_r - base_r) < POS_W'(cols_now)))
    else $error("column divide left a bad remainder");

  a_scroll_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WDRAIN) |=> (cursor_r < total_now))
    else $error("cursor off screen after scroll");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    put_we |-> (!wr_pend_r && state_r != S_CLEAR))
    else $error("put write collided with store sweep");

endmodule

`default_nettype wire

// File: sim/text_terminal_cell_writer_core_test.sv
// Self-checking testbench for text_terminal_cell_writer_core: terminal model, driver, monitor.
// Depends on ttcw_pkg and the core RTL; predicts screen cells, cursor and scroll flag per key.
// Random idling on both channels, a long output hold-off, and several screen geometries.
module text_terminal_cell_writer_core_test;
  import ttcw_pkg::*;

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;
  localparam int unsigned STORE_CELLS = DEF_SCREEN_DEPTH;
  localparam int unsigned INDEX_MAX   = (1 << CURSOR_W) - 1;
  localparam logic [CELL_W-1:0] BLANK = {8'd0, 8'd255, 8'h20};
  localparam int unsigned HOLD_AT   = 320;
  localparam int unsigned LONG_HOLD = 300;
  localparam longint unsigned RUN_LIMIT = 64'd1_000_000_000;

  typedef struct packed {
    logic                mode;
    logic [CHAR_W-1:0]   chr;
    logic [CURSOR_W-1:0] idx;
  } keystroke_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic [CHAR_W-1:0]   ch;
    logic [COLOUR_W-1:0] fg;
    logic [COLOUR_W-1:0] bg;
    logic                scrolled;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_mode = 1'b0;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [CURSOR_W-1:0] in_cell_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CURSOR_W-1:0] out_cursor_pos;
  logic [CHAR_W-1:0] out_cell_char;
  logic [COLOUR_W-1:0] out_cell_fg;
  logic [COLOUR_W-1:0] out_cell_bg;
  logic out_scrolled;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // terminal model state
  logic [CELL_W-1:0]   screen_model [STORE_CELLS];
  logic [CURSOR_W-1:0] cursor_model;
  logic [FONT_W-1:0]   font_code;
  logic                wide_mode;
  logic [COLOUR_W-1:0] fg_colour;
  logic [COLOUR_W-1:0] bg_colour;

  keystroke_t   keystrokes[$];
  cell_result_t predicted_results[$];
  keystroke_t   next_key;
  cell_result_t seen;
  cell_result_t want;

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned send_gap = 0;
  bit send_idle = 1'b1;
  int unsigned recv_gap = 0;
  bit recv_idle = 1'b1;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;

  text_terminal_cell_writer_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_pos (out_cursor_pos),
    .out_cell_char  (out_cell_char),
    .out_cell_fg    (out_cell_fg),
    .out_cell_bg    (out_cell_bg),
    .out_scrolled   (out_scrolled),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned screen_cols();
    return wide_mode ? 80 : 71;
  endfunction

  function automatic int unsigned screen_rows(int unsigned cols);
    int unsigned rows;
    int unsigned cap;
    rows = DEF_LINE_COUNT_PIXELS / (int'(font_code) + 3);
    cap = (STORE_CELLS > 16383) ? 16383 : STORE_CELLS;
    if (rows * cols > cap) rows = cap / cols;
    if (rows < 1) rows = 1;
    return rows;
  endfunction

  // Scroll up by whole rows until the position is back on the screen.
  function automatic int unsigned settle_cursor(int unsigned pos);
    int unsigned cols;
    int unsigned rows;
    int unsigned total;
    int unsigned k;
    int unsigned shift;
    cols = screen_cols();
    rows = screen_rows(cols);
    total = rows * cols;
    if (pos < total) return pos;
    k = (pos - total) / cols + 1;
    pos = pos - k * cols;
    shift = (k >= rows) ? total : k * cols;
    for (int unsigned i = 0; i < total; i++)
      screen_model[i] = (i + shift < total) ? screen_model[i + shift] : BLANK;
    return pos;
  endfunction

  function automatic cell_result_t terminal_step(keystroke_t key);
    cell_result_t r;
    int unsigned pos;
    int unsigned cols;
    int unsigned total;
    logic [CELL_W-1:0] stored;
    r = '0;
    pos = cursor_model;
    cols = screen_cols();
    total = cols * screen_rows(cols);
    if (key.mode == MODE_READ) begin
      stored = (key.idx < STORE_CELLS) ? screen_model[key.idx] : '0;
      r.ch = stored[7:0];
      r.fg = stored[15:8];
      r.bg = stored[23:16];
    end else if (key.chr >= CHAR_SPACE && key.chr <= CHAR_TILDE) begin
      if (pos < STORE_CELLS) screen_model[pos] = {bg_colour, fg_colour, key.chr};
      pos = pos + 1;
      r.scrolled = (pos >= total);
      pos = settle_cursor(pos);
    end else if (key.chr == CHAR_CR) begin
      pos = pos - pos % cols;
    end else if (key.chr == CHAR_LF) begin
      pos = pos - pos % cols + cols;
      r.scrolled = (pos >= total);
      pos = settle_cursor(pos);
    end
    cursor_model = pos[CURSOR_W-1:0];
    r.cursor = cursor_model;
    return r;
  endfunction

  function automatic keystroke_t put_key(logic [CHAR_W-1:0] c);
    keystroke_t k;
    k.mode = MODE_PUT;
    k.chr = c;
    k.idx = CURSOR_W'($urandom_range(0, INDEX_MAX));
    return k;
  endfunction

  function automatic keystroke_t read_key(logic [CURSOR_W-1:0] idx);
    keystroke_t k;
    k.mode = MODE_READ;
    k.chr = CHAR_W'($urandom_range(0, 255));
    k.idx = idx;
    return k;
  endfunction

  function automatic keystroke_t random_key(int unsigned w_lf, int unsigned w_cr,
                                            int unsigned w_rd, int unsigned w_noise,
                                            int unsigned span);
    int unsigned roll;
    keystroke_t k;
    roll = $urandom_range(0, 99);
    k = put_key(CHAR_W'($urandom_range(CHAR_SPACE, CHAR_TILDE)));
    if (roll < w_lf) begin
      k.chr = CHAR_LF;
    end else if (roll < w_lf + w_cr) begin
      k.chr = CHAR_CR;
    end else if (roll < w_lf + w_cr + w_rd) begin
      // mostly cells on the screen, some anywhere in the store
      k = read_key(CURSOR_W'(($urandom_range(0, 2) != 0) ? $urandom_range(0, span - 1)
                                                          : $urandom_range(0, INDEX_MAX)));
    end else if (roll < w_lf + w_cr + w_rd + w_noise) begin
      k.chr = CHAR_W'($urandom_range(0, 255));
    end
    return k;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FONT: font_code = val[FONT_W-1:0];
      CFG_WIDE: wide_mode = val[0];
      CFG_TEXT: fg_colour = val;
      CFG_BACK: bg_colour = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_screen(logic [FONT_W-1:0] font, logic wide, logic [COLOUR_W-1:0] fg,
                            logic [COLOUR_W-1:0] bg);
    write_reg(CFG_FONT, CFG_DATA_W'(font));
    write_reg(CFG_WIDE, CFG_DATA_W'(wide));
    write_reg(CFG_TEXT, fg);
    write_reg(CFG_BACK, bg);
  endtask

  task automatic queue_random(int unsigned n, int unsigned w_lf, int unsigned w_cr,
                              int unsigned w_rd, int unsigned w_noise);
    int unsigned span;
    span = screen_cols() * screen_rows(screen_cols());
    repeat (n) keystrokes.push_back(random_key(w_lf, w_cr, w_rd, w_noise, span));
  endtask

  // wait at the rising edge, where valid is settled, until nothing is left in flight
  task automatic drain();
    do @(posedge clk);
    while (keystrokes.size() != 0 || in_valid || predicted_results.size() != 0);
  endtask

  // driver: present keys at the falling edge, hold while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the stalled transaction
    end else if (send_gap != 0) begin
      send_gap = send_gap - 1;
      in_valid <= 1'b0;
    end else if (keystrokes.size() != 0) begin
      next_key = keystrokes.pop_front();
      in_valid <= 1'b1;
      in_mode <= next_key.mode;
      in_char_code <= next_key.chr;
      in_cell_index <= next_key.idx;
      if ($urandom_range(0, 23) == 0) send_idle = !send_idle;
      send_gap = send_idle ? $urandom_range(0, 7) : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: per-result stall draws, plus one long hold-off
  always @(negedge clk) begin
    if (results_seen == HOLD_AT && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (out_took) begin
      if ($urandom_range(0, 23) == 0) recv_idle = !recv_idle;
      recv_gap = recv_idle ? $urandom_range(0, 7) : 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (recv_gap != 0) begin
      recv_gap = recv_gap - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check results against the oldest prediction, then predict accepted keys
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took <= 1'b0;
      out_took <= 1'b0;
    end else begin
      in_took <= in_valid && !in_stall;
      out_took <= out_valid && !out_stall;
      if (out_valid && !out_stall) begin
        seen = {out_cursor_pos, out_cell_char, out_cell_fg, out_cell_bg, out_scrolled};
        if (predicted_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result cursor %0d char %0h", $time, seen.cursor, seen.ch);
        end else begin
          want = predicted_results.pop_front();
          if (seen.cursor != want.cursor) begin
            errors++;
            $display("%0t: cursor_pos expected %0d got %0d", $time, want.cursor, seen.cursor);
          end
          if (seen.ch != want.ch) begin
            errors++;
            $display("%0t: cell_char expected %0h got %0h", $time, want.ch, seen.ch);
          end
          if (seen.fg != want.fg) begin
            errors++;
            $display("%0t: cell_fg expected %0d got %0d", $time, want.fg, seen.fg);
          end
          if (seen.bg != want.bg) begin
            errors++;
            $display("%0t: cell_bg expected %0d got %0d", $time, want.bg, seen.bg);
          end
          if (seen.scrolled != want.scrolled) begin
            errors++;
            $display("%0t: scrolled expected %0b got %0b", $time, want.scrolled, seen.scrolled);
          end
        end
        results_seen++;
      end
      if (in_valid && !in_stall)
        predicted_results.push_back(terminal_step(keystroke_t'({in_mode, in_char_code,
                                                                in_cell_index})));
    end
  end

  initial begin
    for (int unsigned i = 0; i < STORE_CELLS; i++) screen_model[i] = BLANK;
    cursor_model = '0;
    font_code = '0;
    wide_mode = 1'b1;
    fg_colour = TEXT_RESET;
    bg_colour = BACK_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset geometry, boundary bytes, ignored codes, CR/LF, store edges
    keystrokes.push_back(read_key(0));
    keystrokes.push_back(read_key(CURSOR_W'(INDEX_MAX)));
    keystrokes.push_back(put_key(CHAR_SPACE));
    keystrokes.push_back(put_key(CHAR_TILDE));
    keystrokes.push_back(put_key(8'h1F));
    keystrokes.push_back(put_key(8'h7F));
    keystrokes.push_back(put_key(8'h00));
    keystrokes.push_back(put_key(8'hFF));
    keystrokes.push_back(put_key(8'h09));
    keystrokes.push_back(put_key(CHAR_CR));
    keystrokes.push_back(put_key(8'h41));
    keystrokes.push_back(put_key(CHAR_LF));
    keystrokes.push_back(put_key(8'h5A));
    keystrokes.push_back(put_key(CHAR_LF));
    keystrokes.push_back(put_key(CHAR_CR));
    keystrokes.push_back(read_key(0));
    keystrokes.push_back(read_key(1));
    keystrokes.push_back(read_key(80));
    keystrokes.push_back(read_key(160));
    keystrokes.push_back(read_key(12799));
    keystrokes.push_back(read_key(12800));
    drain();

    // tallest, widest screen: mostly line feeds to reach the bottom and scroll
    set_screen(4'd0, 1'b1, 8'h00, 8'hFF);
    queue_random(210, 80, 4, 6, 4);
    drain();

    // shrink with the cursor far past the new screen; CR first must not scroll
    set_screen(4'd15, 1'b0, 8'hFF, 8'h00);
    keystrokes.push_back(put_key(CHAR_CR));
    keystrokes.push_back(put_key(8'h58));
    keystrokes.push_back(read_key(0));
    keystrokes.push_back(put_key(CHAR_LF));
    queue_random(250, 12, 6, 12, 12);
    drain();

    set_screen(4'd7, 1'b1, COLOUR_W'($urandom_range(0, 255)),
               COLOUR_W'($urandom_range(0, 255)));
    queue_random(250, 15, 5, 15, 10);
    drain();

    set_screen(4'd12, 1'b0, COLOUR_W'($urandom_range(0, 255)),
               COLOUR_W'($urandom_range(0, 255)));
    queue_random(270, 8, 5, 30, 10);
    drain();

    repeat (16) @(negedge clk);
    if (errors == 0)
      $display("text_terminal_cell_writer_core_test: PASS");
    else
      $display("text_terminal_cell_writer_core_test: FAIL");
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("text_terminal_cell_writer_core_test: FAIL");
    $finish;
  end

endmodule
